// ===== hdl/kes_pkg.sv =====
// ----------------------------------------------------------------------------
// kes_pkg
// Types, constants and helpers for the Kepler equation solver.
// ----------------------------------------------------------------------------
package kes_pkg;

    localparam int ANGLE_FRAC_BITS = 28;
    localparam int ECC_FRAC_BITS   = 16;
    localparam int WORK_BITS       = 30;
    localparam int CORDIC_STEPS    = 30;

    localparam int ANG_W   = 36;
    localparam int DIV_W   = 61;
    localparam int SQ_W    = 64;
    localparam int CNT_W   = 6;
    localparam int IDX_W   = $clog2(CORDIC_STEPS);
    localparam int ITER_W  = 11;
    localparam int TOL_W   = 16;
    localparam int MAXIT_W = 10;
    localparam int CFG_A_W = 1;
    localparam int CFG_D_W = 16;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 72;

    localparam logic signed [ANG_W-1:0] PI_W      = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_W = 36'sd1686629713;
    localparam logic signed [ANG_W-1:0] TWO_PI_W  = 36'sd6746518852;
    localparam logic signed [ANG_W-1:0] CORDIC_K  = 36'sd652032874;
    localparam logic signed [31:0]      PI_A      = 32'sd843314857;
    localparam logic signed [31:0]      TWO_PI_A  = 32'sd1686629713;

    localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
        30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
        30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
        30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
        30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2
    };

    localparam logic [TOL_W-1:0]   TOL_RESET   = 16'd268;
    localparam logic [MAXIT_W-1:0] MAXIT_RESET = 10'd1000;

    localparam logic [CFG_A_W-1:0] CFG_TOLERANCE = 1'b0;
    localparam logic [CFG_A_W-1:0] CFG_MAX_ITER  = 1'b1;

    localparam logic [1:0] STATUS_NONE    = 2'd0;
    localparam logic [1:0] STATUS_NO_CONV = 2'd1;
    localparam logic [1:0] STATUS_OOB     = 2'd2;
    localparam logic [1:0] STATUS_UNUSED  = 2'd3;

    // shift right, rounding half away from zero
    function automatic logic signed [64:0] rnd_sh(input logic signed [64:0] x,
                                                  input int unsigned s);
        logic [64:0] m;
        m = x[64] ? 65'(-x) : 65'(x);
        m = (m + (65'd1 << (s - 1))) >> s;
        return x[64] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [64:0] x);
        if (x > 65'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (x < -65'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

endpackage

// ===== hdl/kepler_equation_solver_core.sv =====
// ----------------------------------------------------------------------------
// kepler_equation_solver_core
// Newton-Raphson solver of E - e sin E = M with true anomaly output.
// ----------------------------------------------------------------------------
// One beat in, one beat out. The core takes a beat only when idle and holds
// it until the result beat is taken. Each Newton step (their number bounded
// by max_iterations) runs a CORDIC rotation for sine and cosine, two passes
// through a shared multiplier and a bit-serial divider. The tail adds two
// square roots, one more CORDIC rotation and a CORDIC vectoring pass. Each
// 2*pi wrap of an angle before a rotation takes its own pass through ST_RED.
module kepler_equation_solver_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [31:0] mean_anom, [47:32] eccentricity
    input  logic [kes_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [1:0] status, [33:2] ecc_anom, [65:34] true_anom, rest zero
    output logic [kes_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [kes_pkg::CFG_A_W-1:0]     cfg_addr,
    input  logic [kes_pkg::CFG_D_W-1:0]     cfg_wdata
);
    import kes_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RED, ST_ROT, ST_MUL_S, ST_MUL_C, ST_RES, ST_TEST, ST_DIV,
        ST_UPD, ST_SQRT, ST_MUL_Y, ST_MUL_X, ST_VINIT, ST_VEC, ST_FIN, ST_OUT
    } state_t;

    state_t                    state_reg;
    logic                      phase_reg;
    logic [TOL_W-1:0]          tol_reg;
    logic [MAXIT_W-1:0]        maxit_reg;
    logic signed [31:0]        m_reg, e_reg, es_reg, s_reg, c_reg;
    logic [15:0]               ecc_reg;
    logic signed [ANG_W-1:0]   ang_reg, x_reg, y_reg, z_reg;
    logic                      flip_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic signed [64:0]        prod_reg;
    logic signed [34:0]        k_reg;
    logic [29:0]               kp_reg, rem_reg;
    logic [DIV_W-1:0]          q_reg;
    logic [ITER_W-1:0]         it_reg;
    logic [SQ_W-1:0]           sq_n_reg, sq_res_reg;
    logic [31:0]               sp_reg, sm_reg;
    logic [1:0]                status_reg;
    logic signed [31:0]        out_e_reg, out_nu_reg;

    logic [IDX_W-1:0]          idx;
    logic signed [ANG_W-1:0]   sh_x, sh_y, tab;
    logic signed [ANG_W-1:0]   rx, ry, ra, vx, vy, vz;
    logic signed [ANG_W-1:0]   sin_f, cos_f;
    logic signed [31:0]        sin_c, cos_c;
    logic signed [32:0]        mul_a;
    logic signed [31:0]        mul_b;
    logic signed [64:0]        prod_w, r18, r30;
    logic signed [31:0]        ec_w;
    logic signed [32:0]        kp_raw;
    logic signed [34:0]        k_w;
    logic [34:0]               abs_k;
    logic [30:0]               trial;
    logic                      trial_ge;
    logic signed [62:0]        q_s;
    logic signed [31:0]        e_new;
    logic [5:0]                sq_shamt;
    logic [SQ_W-1:0]           sq_bit, sq_sum;
    logic [SQ_W-1:0]           sq_res_w;
    logic                      sq_take;
    logic signed [64:0]        nu_w;
    logic signed [64:0]        nu_adj;
    logic                      no_conv;

    assign idx  = cnt_reg[IDX_W-1:0];
    assign sh_x = x_reg >>> idx;
    assign sh_y = y_reg >>> idx;
    assign tab  = $signed({{(ANG_W-30){1'b0}}, ATAN_TAB[idx]});

    always_comb begin
        if (!ang_reg[ANG_W-1]) begin
            rx = x_reg - sh_y;
            ry = y_reg + sh_x;
            ra = ang_reg - tab;
        end else begin
            rx = x_reg + sh_y;
            ry = y_reg - sh_x;
            ra = ang_reg + tab;
        end
        if (y_reg > 0) begin
            vx = x_reg + sh_y;
            vy = y_reg - sh_x;
            vz = z_reg + tab;
        end else begin
            vx = x_reg - sh_y;
            vy = y_reg + sh_x;
            vz = z_reg - tab;
        end
        sin_f = flip_reg ? -ry : ry;
        cos_f = flip_reg ? -rx : rx;
        if (sin_f > 36'sd1073741824) begin
            sin_c = 32'sd1073741824;
        end else if (sin_f < -36'sd1073741824) begin
            sin_c = -32'sd1073741824;
        end else begin
            sin_c = sin_f[31:0];
        end
        if (cos_f > 36'sd1073741824) begin
            cos_c = 32'sd1073741824;
        end else if (cos_f < -36'sd1073741824) begin
            cos_c = -32'sd1073741824;
        end else begin
            cos_c = cos_f[31:0];
        end
    end

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL_S: begin
                mul_a = $signed({17'd0, ecc_reg});
                mul_b = s_reg;
            end
            ST_MUL_C: begin
                mul_a = $signed({17'd0, ecc_reg});
                mul_b = c_reg;
            end
            ST_MUL_Y: begin
                mul_a = $signed({1'b0, sp_reg});
                mul_b = s_reg;
            end
            ST_MUL_X: begin
                mul_a = $signed({1'b0, sm_reg});
                mul_b = c_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_w = 65'(mul_a) * 65'(mul_b);
    end

    assign r18    = rnd_sh(prod_reg, 18);
    assign r30    = rnd_sh(prod_reg, 30);
    assign ec_w   = r18[31:0];
    assign k_w    = 35'(e_reg) - 35'(es_reg) - 35'(m_reg);
    assign kp_raw = 33'sd268435456 - 33'(ec_w);
    assign abs_k  = k_reg[34] ? 35'(-k_reg) : 35'(k_reg);

    assign trial    = {rem_reg, q_reg[DIV_W-1]};
    assign trial_ge = trial >= {1'b0, kp_reg};
    assign q_s      = k_reg[34] ? -$signed({2'b00, q_reg}) : $signed({2'b00, q_reg});
    assign e_new    = sat32(65'(e_reg) - 65'(q_s));

    assign sq_shamt = 6'd62 - {cnt_reg[4:0], 1'b0};
    assign sq_bit   = SQ_W'(1) << sq_shamt;
    assign sq_sum   = sq_res_reg + sq_bit;
    assign sq_take  = sq_n_reg >= sq_sum;
    assign sq_res_w = sq_take ? ((sq_res_reg >> 1) + sq_bit) : (sq_res_reg >> 1);

    assign no_conv = it_reg >= ITER_W'(maxit_reg);
    assign nu_w    = rnd_sh(65'(z_reg) <<< 1, 2);
    assign nu_adj  = (e_reg >= PI_A && e_reg <= TWO_PI_A) ? nu_w + 65'(TWO_PI_A) : nu_w;

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = state_reg == ST_OUT;
    assign m_tdata  = {6'd0, out_nu_reg, out_e_reg, status_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            tol_reg   <= TOL_RESET;
            maxit_reg <= MAXIT_RESET;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
            it_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_TOLERANCE: tol_reg   <= cfg_wdata[TOL_W-1:0];
                    CFG_MAX_ITER:  maxit_reg <= cfg_wdata[MAXIT_W-1:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        m_reg     <= $signed(s_tdata[31:0]);
                        ecc_reg   <= s_tdata[47:32];
                        e_reg     <= $signed(s_tdata[31:0]);
                        ang_reg   <= ANG_W'($signed(s_tdata[31:0])) <<< 2;
                        phase_reg <= 1'b0;
                        it_reg    <= '0;
                        state_reg <= ST_RED;
                    end
                end
                ST_RED: begin
                    if (ang_reg > PI_W) begin
                        ang_reg <= ang_reg - TWO_PI_W;
                    end else if (ang_reg < -PI_W) begin
                        ang_reg <= ang_reg + TWO_PI_W;
                    end else begin
                        if (ang_reg > HALF_PI_W) begin
                            ang_reg  <= ang_reg - PI_W;
                            flip_reg <= 1'b1;
                        end else if (ang_reg < -HALF_PI_W) begin
                            ang_reg  <= ang_reg + PI_W;
                            flip_reg <= 1'b1;
                        end else begin
                            flip_reg <= 1'b0;
                        end
                        x_reg     <= CORDIC_K;
                        y_reg     <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_ROT;
                    end
                end
                ST_ROT: begin
                    x_reg   <= rx;
                    y_reg   <= ry;
                    ang_reg <= ra;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(CORDIC_STEPS - 1)) begin
                        s_reg     <= sin_c;
                        c_reg     <= cos_c;
                        state_reg <= phase_reg ? ST_MUL_Y : ST_MUL_S;
                    end
                end
                ST_MUL_S: begin
                    prod_reg  <= prod_w;
                    state_reg <= ST_MUL_C;
                end
                ST_MUL_C: begin
                    prod_reg  <= prod_w;
                    es_reg    <= r18[31:0];
                    state_reg <= ST_RES;
                end
                ST_RES: begin
                    k_reg     <= k_w;
                    kp_reg    <= (kp_raw < 33'sd1) ? 30'd1 : kp_raw[29:0];
                    state_reg <= ST_TEST;
                end
                ST_TEST: begin
                    if (abs_k < 35'(tol_reg)) begin
                        sq_n_reg   <= SQ_W'({17'(17'd65536 + 17'(ecc_reg)), 44'd0});
                        sq_res_reg <= '0;
                        cnt_reg    <= '0;
                        phase_reg  <= 1'b0;
                        state_reg  <= ST_SQRT;
                    end else if (no_conv) begin
                        it_reg     <= it_reg + 1'b1;
                        sq_n_reg   <= SQ_W'({17'(17'd65536 + 17'(ecc_reg)), 44'd0});
                        sq_res_reg <= '0;
                        cnt_reg    <= '0;
                        phase_reg  <= 1'b0;
                        state_reg  <= ST_SQRT;
                    end else begin
                        it_reg    <= it_reg + 1'b1;
                        rem_reg   <= '0;
                        q_reg     <= {abs_k[32:0], 28'd0};
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_reg <= trial_ge ? 30'(trial - {1'b0, kp_reg}) : trial[29:0];
                    q_reg   <= {q_reg[DIV_W-2:0], trial_ge};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DIV_W - 1)) begin
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    e_reg     <= e_new;
                    ang_reg   <= ANG_W'(e_new) <<< 2;
                    state_reg <= ST_RED;
                end
                ST_SQRT: begin
                    if (cnt_reg == CNT_W'(31)) begin
                        cnt_reg <= '0;
                        if (!phase_reg) begin
                            sp_reg     <= sq_res_w[31:0];
                            sq_n_reg   <= SQ_W'({17'(17'd65536 - 17'(ecc_reg)), 44'd0});
                            sq_res_reg <= '0;
                            phase_reg  <= 1'b1;
                        end else begin
                            sm_reg    <= sq_res_w[31:0];
                            ang_reg   <= ANG_W'(e_reg) <<< 1;
                            state_reg <= ST_RED;
                        end
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (sq_take) begin
                            sq_n_reg <= sq_n_reg - sq_sum;
                        end
                        sq_res_reg <= sq_res_w;
                    end
                end
                ST_MUL_Y: begin
                    prod_reg  <= prod_w;
                    state_reg <= ST_MUL_X;
                end
                ST_MUL_X: begin
                    prod_reg  <= prod_w;
                    y_reg     <= ANG_W'(r30);
                    state_reg <= ST_VINIT;
                end
                ST_VINIT: begin
                    if (r30[64]) begin
                        x_reg <= ANG_W'(-r30);
                        y_reg <= -y_reg;
                    end else begin
                        x_reg <= ANG_W'(r30);
                    end
                    z_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_VEC;
                end
                ST_VEC: begin
                    x_reg   <= vx;
                    y_reg   <= vy;
                    z_reg   <= vz;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(CORDIC_STEPS - 1)) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (e_reg >= PI_A && e_reg <= TWO_PI_A) begin
                        status_reg <= no_conv ? STATUS_NO_CONV : STATUS_NONE;
                    end else if (e_reg < 0 || e_reg > TWO_PI_A) begin
                        status_reg <= STATUS_OOB;
                    end else begin
                        status_reg <= no_conv ? STATUS_NO_CONV : STATUS_NONE;
                    end
                    out_e_reg  <= e_reg;
                    out_nu_reg <= sat32(nu_adj);
                    state_reg  <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/kes_checker.sv =====
// ----------------------------------------------------------------------------
// kes_checker
// Port-level checks on the Kepler equation solver, bound to the solver core.
// ----------------------------------------------------------------------------
module kes_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [kes_pkg::M_TDATA_W-1:0] m_tdata
);
    import kes_pkg::*;

    // result beat holds while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // one item in flight: never ready while a result is pending
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && !m_tvalid)
        else $error("core not busy after accepting a beat");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != STATUS_UNUSED)
        else $error("invalid status code");

endmodule

bind kepler_equation_solver_core kes_checker u_kes_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== dv/tb_kepler_equation_solver_core.sv =====
// ----------------------------------------------------------------------------
// tb_kepler_equation_solver_core
// Self-checking bench for the Kepler equation solver core.
// ----------------------------------------------------------------------------
// A table of directed beats and register writes is walked first. Rows with
// an obvious answer carry a typed status and eccentric anomaly. A block of
// random phases follows, each under its own tolerance and iteration limit.
// Each result beat is checked field by field against a bit-true predictor.
// Both sides idle and stall in random bursts, except in the final phase.
// ----------------------------------------------------------------------------
module tb_kepler_equation_solver_core;
    import kes_pkg::*;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] ecc_anom;
        logic signed [31:0] true_anom;
    } orbit_sol_t;

    typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [CFG_A_W-1:0] addr;
        logic [CFG_D_W-1:0] value;
        logic signed [31:0] mean_anom;
        logic [15:0]        ecc;
        bit                 typed;
        logic [1:0]         status;
        logic signed [31:0] ecc_anom;
    } dir_row_t;

    localparam longint CYCLE_LIMIT = 200000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic cfg_wr_en = 1'b0;
    logic [CFG_A_W-1:0] cfg_addr = '0;
    logic [CFG_D_W-1:0] cfg_wdata = '0;

    logic [15:0] tol_reg;
    logic [9:0]  maxit_reg;
    orbit_sol_t  sol_q[$];
    dir_row_t    dir_tab[$];
    int          mismatches = 0;
    int          beats_in = 0;
    int          beats_out = 0;
    int          n_noconv = 0;
    int          n_oob = 0;
    bit          idle_on = 1'b1;
    longint      cycles = 0;

    kepler_equation_solver_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ---------------- predictor ----------------
    function automatic longint rnd_shr(longint x, int s);
        longint m;
        m = (x < 0) ? -x : x;
        m = (m + (64'sd1 <<< (s - 1))) >>> s;
        return (x < 0) ? -m : m;
    endfunction

    function automatic longint clip32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint clip_unit(longint x);
        if (x > (64'sd1 <<< 30)) return 64'sd1 <<< 30;
        if (x < -(64'sd1 <<< 30)) return -(64'sd1 <<< 30);
        return x;
    endfunction

    function automatic void cordic_rot(longint a, output longint s, output longint c);
        longint x, y, nx;
        bit flip;
        x = longint'(CORDIC_K);
        y = 0;
        flip = 0;
        while (a > PI_W) a -= TWO_PI_W;
        while (a < -PI_W) a += TWO_PI_W;
        if (a > HALF_PI_W) begin
            a -= PI_W;
            flip = 1;
        end else if (a < -HALF_PI_W) begin
            a += PI_W;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (a >= 0) begin
                nx = x - (y >>> i); y = y + (x >>> i); a -= longint'(ATAN_TAB[i]);
            end else begin
                nx = x + (y >>> i); y = y - (x >>> i); a += longint'(ATAN_TAB[i]);
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        s = clip_unit(y);
        c = clip_unit(x);
    endfunction

    function automatic longint cordic_vec(longint x, longint y);
        longint z, nx;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i); y = y - (x >>> i); z += longint'(ATAN_TAB[i]);
            end else begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= longint'(ATAN_TAB[i]);
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic longint floor_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic void kepler_residual(longint ea, longint m, longint e,
                                            output longint f, output longint fd);
        longint s, c;
        cordic_rot(ea * 4, s, c);
        f = ea - rnd_shr(e * s, 18) - m;
        fd = (64'sd1 <<< 28) - rnd_shr(e * c, 18);
        if (fd < 1) fd = 1;
    endfunction

    function automatic orbit_sol_t solve_orbit(logic signed [31:0] mean_anom,
                                               logic [15:0] ecc);
        orbit_sol_t r;
        longint m, e, ea, f, fd, af, s, c, sp, sm, x, y, nu;
        int unsigned steps;
        m = longint'(mean_anom);
        e = longint'(ecc);
        steps = 0;
        ea = m;
        kepler_residual(ea, m, e, f, fd);
        forever begin
            af = (f < 0) ? -f : f;
            if (af < longint'(tol_reg)) break;
            if (steps >= maxit_reg) begin
                steps++;
                break;
            end
            steps++;
            ea = clip32(ea - (f * (64'sd1 <<< 28)) / fd);
            kepler_residual(ea, m, e, f, fd);
        end
        r.status = (steps >= maxit_reg) ? STATUS_NO_CONV : STATUS_NONE;
        sp = floor_sqrt(longint'(((65536 + e) <<< 14) <<< 30));
        sm = floor_sqrt(longint'(((65536 - e) <<< 14) <<< 30));
        cordic_rot((ea * 4) >>> 1, s, c);
        y = rnd_shr(sp * s, 30);
        x = rnd_shr(sm * c, 30);
        if (x < 0) begin
            x = -x;
            y = -y;
        end
        nu = rnd_shr(2 * cordic_vec(x, y), 2);
        if (ea >= longint'(PI_A) && ea <= longint'(TWO_PI_A)) begin
            nu += longint'(TWO_PI_A);
        end else if (ea < 0 || ea > longint'(TWO_PI_A)) begin
            r.status = STATUS_OOB;
        end
        nu = clip32(nu);
        r.ecc_anom = ea[31:0];
        r.true_anom = nu[31:0];
        return r;
    endfunction

    // ---------------- checking ----------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0d] %s: got %h, want %h", cycles, what, got, want);
        mismatches++;
    endtask

    initial begin
        int stall;
        orbit_sol_t w;
        stall = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles", cycles);
                $display("Mismatches found");
                $finish;
            end
            if (aresetn && m_tvalid && m_tready) begin
                beats_out++;
                if (sol_q.size() == 0) begin
                    report_mismatch("unexpected beat", m_tdata[31:0], '0);
                end else begin
                    w = sol_q.pop_front();
                    if (m_tdata[1:0] != w.status)
                        report_mismatch("status", 32'(m_tdata[1:0]), 32'(w.status));
                    if (m_tdata[33:2] != w.ecc_anom)
                        report_mismatch("eccentric anomaly", m_tdata[33:2], w.ecc_anom);
                    if (m_tdata[65:34] != w.true_anom)
                        report_mismatch("true anomaly", m_tdata[65:34], w.true_anom);
                    if (m_tdata[M_TDATA_W-1:66] != '0)
                        report_mismatch("padding", 32'(m_tdata[M_TDATA_W-1:66]), '0);
                    if (w.status == STATUS_NO_CONV) n_noconv++;
                    if (w.status == STATUS_OOB) n_oob++;
                end
            end
            if (stall > 0) begin
                stall--;
                m_tready <= (stall == 0);
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 11);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic send_beat(logic signed [31:0] mean_anom, logic [15:0] ecc,
                             bit typed, logic [1:0] st, logic signed [31:0] ea);
        orbit_sol_t w;
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {ecc, mean_anom};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        w = solve_orbit(mean_anom, ecc);
        if (typed) begin
            w.status = st;
            w.ecc_anom = ea;
        end
        sol_q.push_back(w);
        beats_in++;
    endtask

    task automatic write_reg(logic [CFG_A_W-1:0] addr, logic [CFG_D_W-1:0] value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sol_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (addr == CFG_TOLERANCE) tol_reg = value;
        else maxit_reg = value[9:0];
    endtask

    task automatic add_cfg(logic [CFG_A_W-1:0] addr, logic [CFG_D_W-1:0] value);
        dir_row_t r;
        r = '{ROW_CFG, addr, value, 0, 0, 0, 0, 0};
        dir_tab.push_back(r);
    endtask

    task automatic add_beat(logic signed [31:0] m, logic [15:0] e, bit typed,
                            logic [1:0] st, logic signed [31:0] ea);
        dir_row_t r;
        r = '{ROW_BEAT, '0, '0, m, e, typed, st, ea};
        dir_tab.push_back(r);
    endtask

    initial begin
        logic signed [31:0] m;
        logic [15:0] e;
        int tols[6];
        int maxits[6];
        int wild_pct[6];
        tol_reg = TOL_RESET;
        maxit_reg = MAXIT_RESET;

        // zero eccentricity: E equals M, so status is read off the bounds alone
        add_beat(0, 0, 1, STATUS_NONE, 0);
        add_beat(PI_A, 0, 1, STATUS_NONE, PI_A);
        add_beat(TWO_PI_A, 0, 1, STATUS_NONE, TWO_PI_A);
        add_beat(TWO_PI_A + 1, 0, 1, STATUS_OOB, TWO_PI_A + 1);
        add_beat(-1, 0, 1, STATUS_OOB, -1);
        add_beat(32'sh80000000, 0, 1, STATUS_OOB, 32'sh80000000);
        add_beat(32'sh7FFFFFFF, 0, 1, STATUS_OOB, 32'sh7FFFFFFF);
        add_beat(PI_A, 16'hFFFF, 0, 0, 0);
        add_beat(PI_A / 2, 16'hFFFF, 0, 0, 0);
        add_beat(PI_A - 1, 16'd32768, 0, 0, 0);
        add_beat(TWO_PI_A - 5, 16'd1, 0, 0, 0);
        add_beat(PI_A + PI_A / 3, 16'd50000, 0, 0, 0);
        // zero tolerance runs to the iteration limit
        add_cfg(CFG_TOLERANCE, 16'd0);
        add_cfg(CFG_MAX_ITER, 16'd3);
        add_beat(PI_A, 0, 1, STATUS_NO_CONV, PI_A);
        add_beat(200000000, 16'd30000, 0, 0, 0);
        // zero iteration limit flags every beat
        add_cfg(CFG_TOLERANCE, 16'hFFFF);
        add_cfg(CFG_MAX_ITER, 16'd0);
        add_beat(0, 0, 1, STATUS_NO_CONV, 0);
        add_beat(-5, 0, 1, STATUS_OOB, -5);
        add_beat(700000000, 16'd40000, 0, 0, 0);
        add_cfg(CFG_MAX_ITER, 16'd1023);
        add_beat(900000000, 16'd20000, 0, 0, 0);
        add_beat(32'sh80000000, 16'hFFFF, 0, 0, 0);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                write_reg(dir_tab[i].addr, dir_tab[i].value);
            end else begin
                send_beat(dir_tab[i].mean_anom, dir_tab[i].ecc, dir_tab[i].typed,
                          dir_tab[i].status, dir_tab[i].ecc_anom);
            end
        end

        tols     = '{1, 65535, 0, 5000, 40, 268};
        maxits   = '{60, 1023, 2, 0, 25, 1000};
        wild_pct = '{30, 10, 50, 50, 30, 0};
        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_TOLERANCE, 16'(tols[p]));
            write_reg(CFG_MAX_ITER, 16'(maxits[p]));
            idle_on = (p != 5);
            for (int n = 0; n < 188; n++) begin
                if ($urandom_range(0, 99) < wild_pct[p] || maxits[p] <= 2) begin
                    m = $urandom;
                    e = $urandom_range(0, 65535);
                end else begin
                    m = $urandom_range(0, TWO_PI_A);
                    if ($urandom_range(0, 7) == 0) m = m - 32'sd300000000;
                    e = $urandom_range(0, 58000);
                end
                send_beat(m, e, 0, 0, 0);
            end
        end

        s_tvalid <= 1'b0;
        while (sol_q.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        $display("Sent %0d beats, checked %0d results over the directed table and six random phases",
                 beats_in, beats_out);
        $display("Results flagged: %0d no convergence, %0d out of bounds",
                 n_noconv, n_oob);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
